// ===== rtl/core/rpy_pair_mobility_tensor_unit_defines.svh =====
// Assertion macros shared by the pair mobility tensor RTL.
// Included by the top level; no other dependencies.
`ifndef RPY_PAIR_MOBILITY_TENSOR_UNIT_DEFINES_SVH
`define RPY_PAIR_MOBILITY_TENSOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPMT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpmt: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpmt: next-cycle check failed");

`endif

// ===== rtl/core/rpmt_pkg.sv =====
// Shared types and constants of the pair mobility tensor unit.
// No dependencies; rpmt_sqrt, rpmt_tensor and the top use it.
`default_nettype none

package rpmt_pkg;

    localparam int DATA_W            = 32;
    localparam int BOX_W             = 31;
    localparam int OUT_FRAC_BITS_DEF = 24;

    localparam logic [BOX_W-1:0] BOX_RESET = 31'd6553600;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // Per-word control that rides along the pipeline.
    typedef struct packed {
        logic mode;
        logic zero;
        logic far;
    } ctl_t;

    // Side data carried through the square-root pipeline.
    typedef struct packed {
        ctl_t             ctl;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
    } sq_side_t;

    // Side data carried through the reciprocal divider.
    typedef struct packed {
        ctl_t        ctl;
        logic [31:0] rq;
        logic [5:0]  fr;
    } dv_side_t;

endpackage

`default_nettype wire

// ===== rtl/core/rpmt_if.sv =====
// Valid/ready channel interfaces for the pair mobility tensor unit.
// Depends on nothing but plain logic types.
`default_nettype none

interface rpmt_pair_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic               mode;

    modport source (output valid, dx, dy, dz, mode, input ready);
    modport sink   (input valid, dx, dy, dz, mode, output ready);
endinterface

interface rpmt_tensor_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] t_xx;
    logic signed [31:0] t_xy;
    logic signed [31:0] t_xz;
    logic signed [31:0] t_yx;
    logic signed [31:0] t_yy;
    logic signed [31:0] t_yz;
    logic signed [31:0] t_zx;
    logic signed [31:0] t_zy;
    logic signed [31:0] t_zz;
    logic        [1:0]  status;

    modport source (output valid, t_xx, t_xy, t_xz, t_yx, t_yy, t_yz, t_zx, t_zy, t_zz,
                    status, input ready);
    modport sink   (input valid, t_xx, t_xy, t_xz, t_yx, t_yy, t_yz, t_zx, t_zy, t_zz,
                    status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rpmt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Standalone; the stall enable is shared with the rest of the pipeline.
`default_nettype none

module rpmt_div #(
    parameter int DVD_W  = 64,
    parameter int DVS_W  = 32,
    parameter int Q_W    = 33,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [DVD_W-1:0]  dvd,
    input  wire logic [DVS_W-1:0]  dvs,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [Q_W-1:0]         quo,
    output logic [DVS_W:0]         rem,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int REM_W = DVS_W + 1;

    logic              vld_reg  [Q_W];
    logic [REM_W-1:0]  rem_reg  [Q_W];
    logic [Q_W-1:0]    low_reg  [Q_W];
    logic [Q_W-1:0]    quo_reg  [Q_W];
    logic [DVS_W-1:0]  dvs_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++)
        begin : g_step
            logic              vld_src;
            logic [REM_W-1:0]  rem_src;
            logic [Q_W-1:0]    low_src;
            logic [Q_W-1:0]    quo_src;
            logic [DVS_W-1:0]  dvs_src;
            logic [SIDE_W-1:0] side_src;
            logic [REM_W:0]    trial;
            logic              ge;
            logic [REM_W-1:0]  rem_next;

            if (k == 0)
            begin : g_first
                assign vld_src  = in_valid;
                assign rem_src  = REM_W'(dvd >> Q_W);
                assign low_src  = dvd[Q_W-1:0];
                assign quo_src  = '0;
                assign dvs_src  = dvs;
                assign side_src = side_in;
            end
            else
            begin : g_later
                assign vld_src  = vld_reg[k-1];
                assign rem_src  = rem_reg[k-1];
                assign low_src  = low_reg[k-1];
                assign quo_src  = quo_reg[k-1];
                assign dvs_src  = dvs_reg[k-1];
                assign side_src = side_reg[k-1];
            end

            assign trial    = {rem_src, low_src[Q_W-1]};
            assign ge       = trial >= (REM_W+1)'(dvs_src);
            assign rem_next = ge ? REM_W'(trial - (REM_W+1)'(dvs_src)) : REM_W'(trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    low_reg[k]  <= {low_src[Q_W-2:0], 1'b0};
                    quo_reg[k]  <= {quo_src[Q_W-2:0], ge};
                    dvs_reg[k]  <= dvs_src;
                    side_reg[k] <= side_src;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[Q_W-1];
    assign quo       = quo_reg[Q_W-1];
    assign rem       = rem_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/rpmt_sqrt.sv =====
// Normalizing shift and 32-stage integer square root of the squared distance.
// Depends on rpmt_pkg for the side-data type.
`default_nettype none

module rpmt_sqrt (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [63:0]       rr,
    input  rpmt_pkg::sq_side_t     side_in,
    output logic                   out_valid,
    output logic [31:0]            rq,
    output logic [5:0]             s,
    output rpmt_pkg::sq_side_t     side_out
);

    localparam int STEPS = 32;

    // Normalization, first half: shifts of 32 and 16.
    logic               n0_vld_reg;
    logic [63:0]        n0_v_reg;
    logic [5:0]         n0_s_reg;
    rpmt_pkg::sq_side_t n0_side_reg;
    logic [63:0]        n0_t1;
    logic [63:0]        n0_v_next;
    logic [5:0]         n0_s_next;

    always_comb
    begin
        n0_t1     = (rr[63:32] == '0) ? (rr << 32) : rr;
        n0_v_next = (n0_t1[63:48] == '0) ? (n0_t1 << 16) : n0_t1;
        n0_s_next = ((rr[63:32] == '0) ? 6'd32 : 6'd0)
                  + ((n0_t1[63:48] == '0) ? 6'd16 : 6'd0);
    end

    // Normalization, second half: shifts of 8, 4 and 2.
    logic               n1_vld_reg;
    logic [63:0]        n1_v_reg;
    logic [5:0]         n1_s_reg;
    rpmt_pkg::sq_side_t n1_side_reg;
    logic [63:0]        n1_t1;
    logic [63:0]        n1_t2;
    logic [63:0]        n1_v_next;
    logic [5:0]         n1_s_next;

    always_comb
    begin
        n1_t1     = (n0_v_reg[63:56] == '0) ? (n0_v_reg << 8) : n0_v_reg;
        n1_t2     = (n1_t1[63:60] == '0) ? (n1_t1 << 4) : n1_t1;
        n1_v_next = (n1_t2[63:62] == '0) ? (n1_t2 << 2) : n1_t2;
        n1_s_next = n0_s_reg
                  + ((n0_v_reg[63:56] == '0) ? 6'd8 : 6'd0)
                  + ((n1_t1[63:60] == '0) ? 6'd4 : 6'd0)
                  + ((n1_t2[63:62] == '0) ? 6'd2 : 6'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n0_vld_reg <= 1'b0;
            n1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            n0_vld_reg <= in_valid;
            n1_vld_reg <= n0_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n0_v_reg    <= n0_v_next;
            n0_s_reg    <= n0_s_next;
            n0_side_reg <= side_in;
            n1_v_reg    <= n1_v_next;
            n1_s_reg    <= n1_s_next;
            n1_side_reg <= n0_side_reg;
        end
    end

    // Digit-by-digit root; a nonzero normalized input has its top pair set,
    // so every step starts from a fixed trial bit.
    logic               sq_vld_reg  [STEPS];
    logic [63:0]        sq_v_reg    [STEPS];
    logic [63:0]        sq_res_reg  [STEPS];
    logic [5:0]         sq_s_reg    [STEPS];
    rpmt_pkg::sq_side_t sq_side_reg [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_root
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
            logic               vld_src;
            logic [63:0]        v_src;
            logic [63:0]        res_src;
            logic [5:0]         s_src;
            rpmt_pkg::sq_side_t side_src;
            logic [63:0]        trial;
            logic               take;

            if (k == 0)
            begin : g_first
                assign vld_src  = n1_vld_reg;
                assign v_src    = n1_v_reg;
                assign res_src  = '0;
                assign s_src    = n1_s_reg;
                assign side_src = n1_side_reg;
            end
            else
            begin : g_later
                assign vld_src  = sq_vld_reg[k-1];
                assign v_src    = sq_v_reg[k-1];
                assign res_src  = sq_res_reg[k-1];
                assign s_src    = sq_s_reg[k-1];
                assign side_src = sq_side_reg[k-1];
            end

            assign trial = res_src + BIT;
            assign take  = v_src >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    sq_vld_reg[k] <= vld_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_v_reg[k]    <= take ? (v_src - trial) : v_src;
                    sq_res_reg[k]  <= take ? ((res_src >> 1) + BIT) : (res_src >> 1);
                    sq_s_reg[k]    <= s_src;
                    sq_side_reg[k] <= side_src;
                end
            end
        end
    endgenerate

    assign out_valid = sq_vld_reg[STEPS-1];
    assign rq        = sq_res_reg[STEPS-1][31:0];
    assign s         = sq_s_reg[STEPS-1];
    assign side_out  = sq_side_reg[STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/core/rpmt_tensor.sv =====
// Tensor coefficients, outer products and output conversion (five stages).
// Depends on rpmt_pkg for control types and status codes.
`default_nettype none

module rpmt_tensor #(
    parameter int OUT_FRAC_BITS = rpmt_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [32:0]   mu_x,
    input  wire logic [32:0]   mu_y,
    input  wire logic [32:0]   mu_z,
    input  wire logic [32:0]   a,
    input  wire logic [31:0]   rq,
    input  wire logic [5:0]    fr,
    input  rpmt_pkg::ctl_t     ctl,
    input  wire logic [2:0]    neg,
    output logic               out_valid,
    output logic [5:0][31:0]   ent,
    output logic [1:0]         status
);

    localparam int SH = 32 - OUT_FRAC_BITS;
    // Unique products: xx, yy, zz, xy, xz, yz.
    localparam int PI [6] = '{0, 1, 2, 0, 0, 1};
    localparam int PJ [6] = '{0, 1, 2, 1, 2, 2};

    // Returns {saturated, word}; the magnitude is Q.32.
    function automatic logic [32:0] conv(input logic [63:0] mag, input logic negf);
        logic [63:0] v;
        logic [32:0] r;
        v = mag >> SH;
        if (!negf)
        begin
            if (v > 64'h7FFF_FFFF)
                r = {1'b1, 32'h7FFF_FFFF};
            else
                r = {1'b0, v[31:0]};
        end
        else
        begin
            if (v > 64'h8000_0000)
                r = {1'b1, 32'h8000_0000};
            else
                r = {1'b0, 32'(64'd0 - v)};
        end
        return r;
    endfunction

    logic [2:0][32:0] mu;
    assign mu = {mu_z, mu_y, mu_x};

    logic [4:0]     vld_reg;
    rpmt_pkg::ctl_t ctl_reg [4];
    logic [2:0]     neg_reg [4];

    // Stage 1: a^2, outer products of the unit vector, overlap radius.
    logic [31:0]      s1_a_reg;
    logic [31:0]      s1_aa_reg;
    logic [31:0]      s1_r30_reg;
    logic [5:0][35:0] s1_uu_reg;
    logic [63:0]      s1_aa_prod;
    logic [5:0]       s1_shift;

    assign s1_aa_prod = a[31:0] * a[31:0];
    assign s1_shift   = fr - 6'd30;

    // Stage 2: a^3.
    logic [31:0]      s2_a_reg;
    logic [31:0]      s2_a3_reg;
    logic [31:0]      s2_r30_reg;
    logic [5:0][35:0] s2_uu_reg;
    logic [63:0]      s2_a3_prod;

    assign s2_a3_prod = s1_aa_reg * s1_a_reg;

    // Stage 3: mm1 and c2 for the far or the overlapping form.
    logic [63:0]      s3_mm1_reg;
    logic [31:0]      s3_c2_reg;
    logic [5:0][35:0] s3_uu_reg;
    logic [63:0]      s3_mm1_next;
    logic [31:0]      s3_c2_next;
    logic [33:0]      s3_t;
    logic [34:0]      s3_a3x3;
    logic [35:0]      s3_r9;
    logic [33:0]      s3_r3;

    always_comb
    begin
        s3_t    = (34'(s2_a_reg) * 34'd3) >> 2;
        s3_a3x3 = (35'(s2_a3_reg) * 35'd3) >> 1;
        s3_r9   = (36'(s2_r30_reg) * 36'd9) >> 3;
        s3_r3   = (34'(s2_r30_reg) * 34'd3) >> 3;
        if (ctl_reg[1].far)
        begin
            s3_mm1_next = 64'(s3_t) + 64'(s2_a3_reg >> 1);
            s3_c2_next  = 32'(35'(s3_t) - s3_a3x3);
        end
        else
        begin
            s3_mm1_next = (64'd1 << 32) - 64'(s3_r9);
            s3_c2_next  = s3_r3[31:0];
        end
    end

    // Stage 4: c2 * uu per product.
    logic [63:0]      s4_mm1_reg;
    logic [5:0][31:0] s4_p_reg;

    // Stage 5: output conversion.
    logic [5:0][32:0] s5_conv;
    logic [5:0][31:0] s5_ent_next;
    logic [1:0]       s5_status_next;
    logic [5:0][31:0] ent_reg;
    logic [1:0]       status_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s5_conv[i] = conv(s4_mm1_reg + 64'(s4_p_reg[i]), 1'b0);
        end
        for (int i = 3; i < 6; i++)
        begin
            s5_conv[i] = conv(64'(s4_p_reg[i]), neg_reg[3][PI[i]] ^ neg_reg[3][PJ[i]]);
        end
        if (ctl_reg[3].mode)
        begin
            for (int i = 0; i < 6; i++)
            begin
                s5_ent_next[i] = (i < 3) ? (32'd1 << OUT_FRAC_BITS) : '0;
            end
            s5_status_next = rpmt_pkg::ST_OK;
        end
        else if (ctl_reg[3].zero)
        begin
            s5_ent_next    = '0;
            s5_status_next = rpmt_pkg::ST_ZERO;
        end
        else
        begin
            for (int i = 0; i < 6; i++)
            begin
                s5_ent_next[i] = s5_conv[i][31:0];
            end
            s5_status_next = (s5_conv[0][32] | s5_conv[1][32] | s5_conv[2][32] |
                              s5_conv[3][32] | s5_conv[4][32] | s5_conv[5][32])
                           ? rpmt_pkg::ST_SAT : rpmt_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[0] <= ctl;
            neg_reg[0] <= neg;
            for (int i = 1; i < 4; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end

            s1_a_reg   <= a[31:0];
            s1_aa_reg  <= s1_aa_prod[63:32];
            s1_r30_reg <= rq >> s1_shift;
            for (int i = 0; i < 6; i++)
            begin
                s1_uu_reg[i] <= 36'((66'(mu[PI[i]]) * 66'(mu[PJ[i]])) >> 28);
            end

            s2_a_reg   <= s1_a_reg;
            s2_a3_reg  <= s2_a3_prod[63:32];
            s2_r30_reg <= s1_r30_reg;
            s2_uu_reg  <= s1_uu_reg;

            s3_mm1_reg <= s3_mm1_next;
            s3_c2_reg  <= s3_c2_next;
            s3_uu_reg  <= s2_uu_reg;

            s4_mm1_reg <= s3_mm1_reg;
            for (int i = 0; i < 6; i++)
            begin
                s4_p_reg[i] <= 32'((68'(s3_c2_reg) * 68'(s3_uu_reg[i])) >> 32);
            end

            ent_reg    <= s5_ent_next;
            status_reg <= s5_status_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign ent       = ent_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rpy_pair_mobility_tensor_unit.sv =====
// Rotne-Prager-Yamakawa pair mobility tensor: takes one bead displacement word
// per cycle and returns one 3x3 tensor word per cycle. The pipeline depth is
// set by the three long pipelines: a 32-stage remainder divider for the
// periodic fold, a 32-stage square root and a 33-stage reciprocal divider,
// plus eleven stages of squares, normalization and coefficients. The whole
// pipeline stalls together while the output word is not taken. The box
// length may be written only while the unit holds no word.
// Depends on rpmt_pkg, rpmt_if, rpmt_div, rpmt_sqrt, rpmt_tensor and the defines header.
`default_nettype none
`include "rpy_pair_mobility_tensor_unit_defines.svh"

module rpy_pair_mobility_tensor_unit #(
    parameter int OUT_FRAC_BITS = rpmt_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [rpmt_pkg::BOX_W-1:0] cfg_wdata,
    rpmt_pair_if.sink                      pair,
    rpmt_tensor_if.source                  tensor
);

    logic [rpmt_pkg::BOX_W-1:0] box_reg;
    logic                       en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg <= rpmt_pkg::BOX_RESET;
        end
        else if (cfg_we)
        begin
            box_reg <= cfg_wdata;
        end
    end

    assign en         = !tensor.valid || tensor.ready;
    assign pair.ready = en;

    // Fold: the remainder of |d| by L decides the minimum image.
    logic [2:0][31:0] raw;
    logic [2:0][31:0] mabs;
    logic             fold_vld [3];
    logic [31:0]      fold_rem [3];
    logic [1:0]       fold_side [3];

    assign raw = {pair.dz, pair.dy, pair.dx};

    genvar i;
    generate
        for (i = 0; i < 3; i++)
        begin : g_fold
            assign mabs[i] = raw[i][31] ? (~raw[i] + 32'd1) : raw[i];

            rpmt_div #(
                .DVD_W  (32),
                .DVS_W  (rpmt_pkg::BOX_W),
                .Q_W    (32),
                .SIDE_W (2)
            ) u_fold (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .in_valid (pair.valid),
                .dvd      (mabs[i]),
                .dvs      (box_reg),
                .side_in  ({pair.mode, raw[i][31]}),
                .out_valid(fold_vld[i]),
                .quo      (),
                .rem      (fold_rem[i]),
                .side_out (fold_side[i])
            );
        end
    endgenerate

    logic [2:0][31:0] f_mag_next;
    logic [2:0]       f_neg_next;
    logic [31:0]      box_w;

    assign box_w = {1'b0, box_reg};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (box_reg == '0)
            begin
                f_mag_next[k] = fold_rem[k];
                f_neg_next[k] = fold_side[k][0];
            end
            else if ({fold_rem[k], 1'b0} >= {1'b0, box_w})
            begin
                f_mag_next[k] = box_w - fold_rem[k];
                f_neg_next[k] = !fold_side[k][0];
            end
            else
            begin
                f_mag_next[k] = fold_rem[k];
                f_neg_next[k] = fold_side[k][0];
            end
        end
    end

    // Folded components, their squares, and the squared distance.
    logic               f_vld_reg;
    logic [2:0][31:0]   f_mag_reg;
    logic [2:0]         f_neg_reg;
    logic               f_mode_reg;
    logic               q_vld_reg;
    logic [2:0][63:0]   q_sq_reg;
    logic [2:0][31:0]   q_mag_reg;
    logic [2:0]         q_neg_reg;
    logic               q_mode_reg;
    logic               r_vld_reg;
    logic [63:0]        r_rr_reg;
    rpmt_pkg::sq_side_t r_side_reg;
    logic [63:0]        r_rr_next;

    assign r_rr_next = q_sq_reg[0] + q_sq_reg[1] + q_sq_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
            q_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f_vld_reg <= fold_vld[0];
            q_vld_reg <= f_vld_reg;
            r_vld_reg <= q_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_mag_reg  <= f_mag_next;
            f_neg_reg  <= f_neg_next;
            f_mode_reg <= fold_side[0][1];
            for (int k = 0; k < 3; k++)
            begin
                q_sq_reg[k] <= 64'(f_mag_reg[k]) * 64'(f_mag_reg[k]);
            end
            q_mag_reg  <= f_mag_reg;
            q_neg_reg  <= f_neg_reg;
            q_mode_reg <= f_mode_reg;
            r_rr_reg            <= r_rr_next;
            r_side_reg.ctl.mode <= q_mode_reg;
            r_side_reg.ctl.zero <= r_rr_next == '0;
            r_side_reg.ctl.far  <= r_rr_next >= (64'd4 << 32);
            r_side_reg.neg      <= q_neg_reg;
            r_side_reg.mag      <= q_mag_reg;
        end
    end

    // Square root of the normalized squared distance.
    logic               sq_vld;
    logic [31:0]        sq_rq;
    logic [5:0]         sq_s;
    rpmt_pkg::sq_side_t sq_side;

    rpmt_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (r_vld_reg),
        .rr       (r_rr_reg),
        .side_in  (r_side_reg),
        .out_valid(sq_vld),
        .rq       (sq_rq),
        .s        (sq_s),
        .side_out (sq_side)
    );

    // Dividends for the unit vector and for 1/r.
    logic [5:0]         d_fr_next;
    logic [5:0]         d_sh_next;
    logic [6:0]         d_ash_next;
    logic               d_vld_reg;
    logic [2:0][63:0]   d_mu_reg;
    logic [63:0]        d_a_reg;
    logic [2:0]         d_neg_reg;
    rpmt_pkg::dv_side_t d_side_reg;

    assign d_fr_next  = 6'd16 + {1'b0, sq_s[5:1]};
    assign d_sh_next  = 6'd30 + {1'b0, sq_s[5:1]};
    assign d_ash_next = 7'd32 + 7'(d_fr_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            d_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d_mu_reg[k] <= 64'(sq_side.mag[k]) << d_sh_next;
            end
            d_a_reg        <= sq_side.ctl.far ? (64'd1 << d_ash_next) : '0;
            d_neg_reg      <= sq_side.neg;
            d_side_reg.ctl <= sq_side.ctl;
            d_side_reg.rq  <= sq_rq;
            d_side_reg.fr  <= d_fr_next;
        end
    end

    logic [32:0]        mu_q [3];
    logic               mu_vld [3];
    logic               mu_neg [3];
    logic [32:0]        a_q;
    logic               a_vld;
    rpmt_pkg::dv_side_t a_side;

    generate
        for (i = 0; i < 3; i++)
        begin : g_unit
            rpmt_div #(
                .DVD_W  (64),
                .DVS_W  (32),
                .Q_W    (33),
                .SIDE_W (1)
            ) u_mu (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .in_valid (d_vld_reg),
                .dvd      (d_mu_reg[i]),
                .dvs      (d_side_reg.rq),
                .side_in  (d_neg_reg[i]),
                .out_valid(mu_vld[i]),
                .quo      (mu_q[i]),
                .rem      (),
                .side_out (mu_neg[i])
            );
        end
    endgenerate

    rpmt_div #(
        .DVD_W  (64),
        .DVS_W  (32),
        .Q_W    (33),
        .SIDE_W ($bits(rpmt_pkg::dv_side_t))
    ) u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (d_vld_reg),
        .dvd      (d_a_reg),
        .dvs      (d_side_reg.rq),
        .side_in  (d_side_reg),
        .out_valid(a_vld),
        .quo      (a_q),
        .rem      (),
        .side_out (a_side)
    );

    logic [5:0][31:0] ent;

    rpmt_tensor #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_tensor (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (a_vld && mu_vld[0]),
        .mu_x     (mu_q[0]),
        .mu_y     (mu_q[1]),
        .mu_z     (mu_q[2]),
        .a        (a_q),
        .rq       (a_side.rq),
        .fr       (a_side.fr),
        .ctl      (a_side.ctl),
        .neg      ({mu_neg[2], mu_neg[1], mu_neg[0]}),
        .out_valid(tensor.valid),
        .ent      (ent),
        .status   (tensor.status)
    );

    // The tensor is symmetric: each off-diagonal word feeds two entries.
    assign tensor.t_xx = ent[0];
    assign tensor.t_yy = ent[1];
    assign tensor.t_zz = ent[2];
    assign tensor.t_xy = ent[3];
    assign tensor.t_yx = ent[3];
    assign tensor.t_xz = ent[4];
    assign tensor.t_zx = ent[4];
    assign tensor.t_yz = ent[5];
    assign tensor.t_zy = ent[5];

    `RPMT_ASSERT_IMPL(a_zero_clears, clk, rst_n, tensor.valid && tensor.status == rpmt_pkg::ST_ZERO, tensor.t_xx == '0 && tensor.t_yy == '0 && tensor.t_zz == '0 && tensor.t_xy == '0)
    `RPMT_ASSERT_IMPL(a_symmetric, clk, rst_n, tensor.valid, tensor.t_xy == tensor.t_yx && tensor.t_xz == tensor.t_zx && tensor.t_yz == tensor.t_zy)
    `RPMT_ASSERT_IMPL(a_status_code, clk, rst_n, tensor.valid, tensor.status == rpmt_pkg::ST_OK || tensor.status == rpmt_pkg::ST_ZERO || tensor.status == rpmt_pkg::ST_SAT)
    `RPMT_ASSERT_IMPL(a_stall_cause, clk, rst_n, !pair.ready, tensor.valid && !tensor.ready)

endmodule

`default_nettype wire

// ===== verif/tb_rpy_pair_mobility_tensor_unit.sv =====
// Testbench for the pair mobility tensor unit: drives displacement words with random idling,
// predicts each tensor word in fixed point and compares it field by field.
// Depends on rpmt_pkg, rpmt_if and the rpy_pair_mobility_tensor_unit RTL.
`timescale 1ns / 1ps

module tb_rpy_pair_mobility_tensor_unit;

    localparam int FRAC = 24;
    localparam int LATENCY = 108;

    typedef struct {
        logic [31:0] t [9];
        logic [1:0]  status;
    } tensor_word_t;

    typedef struct {
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] dz;
        logic        mode;
        bit          typed;
        logic [31:0] t_xx;
        logic [1:0]  status;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [rpmt_pkg::BOX_W-1:0] cfg_wdata;

    rpmt_pair_if   pair ();
    rpmt_tensor_if tensor ();

    rpy_pair_mobility_tensor_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .pair(pair), .tensor(tensor)
    );

    logic [63:0]  box_len;
    tensor_word_t expected_tensors [$];
    int           errors;
    bit           no_idle;
    int           sink_hold;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] fold_component(logic [31:0] raw, output bit neg);
        logic [63:0] m;
        logic [63:0] q;
        longint      t;
        neg = raw[31];
        m = neg ? (64'd1 << 32) - {32'd0, raw} : {32'd0, raw};
        if (box_len != 0)
        begin
            q = (2 * m + box_len) / (2 * box_len);
            t = longint'(m) - longint'(q * box_len);
            if (t < 0)
            begin
                neg = !neg;
                m = -t;
            end
            else
                m = t;
        end
        return m;
    endfunction

    function automatic logic [31:0] saturate_entry(logic [63:0] mag, bit neg, ref bit sat);
        logic [63:0] v;
        v = mag >> (32 - FRAC);
        if (!neg)
        begin
            if (v > 64'h7FFFFFFF)
            begin
                v = 64'h7FFFFFFF;
                sat = 1;
            end
            return v[31:0];
        end
        if (v > 64'h80000000)
        begin
            v = 64'h80000000;
            sat = 1;
        end
        return 32'(64'd0 - v);
    endfunction

    function automatic tensor_word_t mobility_tensor(logic [31:0] dx, logic [31:0] dy,
                                                     logic [31:0] dz, logic mode);
        tensor_word_t w;
        logic [63:0] mag [3];
        logic [63:0] mu [3];
        bit          neg [3];
        logic [31:0] raw [3];
        logic [63:0] rr, rq, mm1, c2, a, a3, r30, uu, p;
        int          s, fr;
        bit          sat;
        raw[0] = dx;
        raw[1] = dy;
        raw[2] = dz;
        sat = 0;
        if (mode)
        begin
            for (int i = 0; i < 9; i++)
                w.t[i] = (i % 4 == 0) ? 32'd1 << FRAC : 32'd0;
            w.status = rpmt_pkg::ST_OK;
            return w;
        end
        rr = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = fold_component(raw[i], neg[i]);
            rr = rr + mag[i] * mag[i];
        end
        if (rr == 0)
        begin
            for (int i = 0; i < 9; i++)
                w.t[i] = 0;
            w.status = rpmt_pkg::ST_ZERO;
            return w;
        end
        s = 0;
        while (s < 62 && (rr >> (62 - s)) == 0)
            s += 2;
        rq = int_sqrt(rr << s);
        fr = 16 + s / 2;
        for (int i = 0; i < 3; i++)
            mu[i] = (mag[i] << (14 + fr)) / rq;
        if (rr >= (64'd4 << 32))
        begin
            a = (64'd1 << (32 + fr)) / rq;
            a3 = (((a * a) >> 32) * a) >> 32;
            mm1 = ((3 * a) >> 2) + (a3 >> 1);
            c2 = ((3 * a) >> 2) - ((3 * a3) >> 1);
        end
        else
        begin
            r30 = rq >> (fr - 30);
            mm1 = (64'd1 << 32) - ((9 * r30) >> 3);
            c2 = (3 * r30) >> 3;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                uu = (mu[i] * mu[j]) >> 28;
                p = (c2 * uu) >> 32;
                if (i == j)
                    w.t[i * 3 + j] = saturate_entry(mm1 + p, 0, sat);
                else
                    w.t[i * 3 + j] = saturate_entry(p, neg[i] != neg[j], sat);
            end
        w.status = sat ? rpmt_pkg::ST_SAT : rpmt_pkg::ST_OK;
        return w;
    endfunction

    // Sink side: random stalls, then compare each taken word with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tensor.ready <= 1'b0;
            sink_hold <= 0;
        end
        else
        begin
            if (tensor.valid && tensor.ready)
            begin
                if (expected_tensors.size() == 0)
                begin
                    $display("%0t: tensor word with none expected", $time);
                    errors++;
                end
                else
                begin
                    tensor_word_t e;
                    logic [31:0]  got [9];
                    e = expected_tensors.pop_front();
                    got = '{tensor.t_xx, tensor.t_xy, tensor.t_xz, tensor.t_yx,
                            tensor.t_yy, tensor.t_yz, tensor.t_zx, tensor.t_zy, tensor.t_zz};
                    for (int k = 0; k < 9; k++)
                        if (got[k] !== e.t[k])
                        begin
                            $display("%0t: entry %0d expected %h actual %h",
                                     $time, k, e.t[k], got[k]);
                            errors++;
                        end
                    if (tensor.status !== e.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, tensor.status);
                        errors++;
                    end
                end
            end
            if (sink_hold > 0)
                sink_hold <= sink_hold - 1;
            if (!no_idle && sink_hold == 0 && $urandom_range(0, 15) == 0)
            begin
                sink_hold <= $urandom_range(1, 18);
                tensor.ready <= 1'b0;
            end
            else
                tensor.ready <= (sink_hold <= 1) || no_idle;
        end
    end

    // Valid stays high between back-to-back words; it drops only for idling and draining.
    task automatic send_pair(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz, logic mode);
        if (!no_idle && $urandom_range(0, 9) == 0)
        begin
            pair.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        pair.valid <= 1'b1;
        pair.dx <= dx;
        pair.dy <= dy;
        pair.dz <= dz;
        pair.mode <= mode;
        expected_tensors.push_back(mobility_tensor(dx, dy, dz, mode));
        @(posedge clk);
        while (!pair.ready)
            @(posedge clk);
    endtask

    task automatic drain_pipeline();
        pair.valid <= 1'b0;
        while (expected_tensors.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_box(logic [rpmt_pkg::BOX_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        box_len = value;
    endtask

    function automatic logic [31:0] rand_disp(int shape);
        case (shape)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
            2: return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
            default: return $signed($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000;
        endcase
    endfunction

    stim_row_t directed [] = '{
        '{32'h0, 32'h0, 32'h0, 1'b1, 1, 32'h0100_0000, rpmt_pkg::ST_OK},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b1, 1, 32'h0100_0000,
          rpmt_pkg::ST_OK},
        '{32'h0, 32'h0, 32'h0, 1'b0, 1, 32'h0, rpmt_pkg::ST_ZERO},
        '{32'h0064_0000, 32'hFF9C_0000, 32'h00C8_0000, 1'b0, 1, 32'h0, rpmt_pkg::ST_ZERO},
        '{32'h0002_0000, 32'h0, 32'h0, 1'b0, 0, 32'h0, rpmt_pkg::ST_OK},
        '{32'h0001_0000, 32'h0, 32'h0, 1'b0, 0, 32'h0, rpmt_pkg::ST_OK},
        '{32'h0000_0001, 32'h0, 32'h0, 1'b0, 0, 32'h0, rpmt_pkg::ST_OK},
        '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 0, 32'h0, rpmt_pkg::ST_OK},
        '{32'h0001_FFFF, 32'h0, 32'h0, 1'b0, 0, 32'h0, rpmt_pkg::ST_OK},
        '{32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 1'b0, 0, 32'h0, rpmt_pkg::ST_OK},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0032_0000, 1'b0, 0, 32'h0, rpmt_pkg::ST_OK},
        '{32'h0031_8000, 32'hFFCE_8000, 32'h0032_0000, 1'b0, 0, 32'h0, rpmt_pkg::ST_OK},
        '{32'h0005_0000, 32'h0003_0000, 32'hFFFE_0000, 1'b0, 0, 32'h0, rpmt_pkg::ST_OK}
    };

    initial
    begin
        logic [rpmt_pkg::BOX_W-1:0] boxes [6];
        int shape;
        errors = 0;
        no_idle = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        pair.valid = 1'b0;
        pair.dx = '0;
        pair.dy = '0;
        pair.dz = '0;
        pair.mode = 1'b0;
        box_len = rpmt_pkg::BOX_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[n])
        begin
            if (directed[n].typed)
            begin
                tensor_word_t m;
                m = mobility_tensor(directed[n].dx, directed[n].dy, directed[n].dz,
                                    directed[n].mode);
                if (m.t[0] !== directed[n].t_xx || m.status !== directed[n].status)
                begin
                    $display("%0t: row %0d expected %h/%0d actual %h/%0d", $time, n,
                             directed[n].t_xx, directed[n].status, m.t[0], m.status);
                    errors++;
                end
            end
            send_pair(directed[n].dx, directed[n].dy, directed[n].dz, directed[n].mode);
        end
        drain_pipeline();

        // Box lengths: zero disables folding, then the extremes and a few in between.
        boxes = '{31'd0, 31'd65536, 31'h7FFF_FFFF, 31'd262144, rpmt_pkg::BOX_RESET, 31'd0};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_box(boxes[ph]);
            send_pair(32'h0001_0000, 32'h0, 32'h0, 1'b0);
            send_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0);
            for (int n = 0; n < 270; n++)
            begin
                if (ph == 5)
                    no_idle = (n > 150);
                if (ph == 3 && n == 100)
                begin
                    pair.valid <= 1'b0;
                    while (expected_tensors.size() != 0)
                        @(posedge clk);
                end
                shape = $urandom_range(0, 3);
                if ($urandom_range(0, 11) == 0)
                    send_pair($urandom(), $urandom(), $urandom(), 1'b1);
                else
                    send_pair(rand_disp(shape), rand_disp(shape), rand_disp(shape), 1'b0);
            end
            drain_pipeline();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rpmt_pkg.sv
rtl/core/rpmt_if.sv
rtl/core/rpmt_div.sv
rtl/core/rpmt_sqrt.sv
rtl/core/rpmt_tensor.sv
rtl/core/rpy_pair_mobility_tensor_unit.sv
verif/tb_rpy_pair_mobility_tensor_unit.sv
